/* hw/rtl/sfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer: item kinds,
// sequencer states, stream field positions and divider status.
// ----------------------------------------------------------------------------
package sfs_pkg;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_SELECT     = 3'd1,
		OP_LOAD_FRAME = 3'd2,
		OP_LOAD_SEQ   = 3'd3,
		OP_PAUSE      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEQ_RD,
		ST_TICK,
		ST_DIV_CNT,
		ST_ADVANCE,
		ST_DIV_WRAP,
		ST_FRAME_WB,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam int OP_W        = 3;
	localparam int IN_TDATA_W  = 208;
	localparam int OUT_TDATA_W = 144;
	localparam int BOX_W       = 64;
	localparam int IDX_W       = 8;
	localparam int FIELD_T_W   = 24;

	// Input item field positions in s_tdata.
	localparam int IN_DELTA_LO  = 0;
	localparam int IN_VIS_BIT   = 24;
	localparam int IN_SLOT_LO   = 25;
	localparam int IN_BEGIN_LO  = 33;
	localparam int IN_END_LO    = 41;
	localparam int IN_PERIOD_LO = 49;
	localparam int IN_TEX_LO    = 73;
	localparam int IN_SPR_LO    = 137;

	// Result item field positions in m_tdata.
	localparam int OUT_TEX_LO     = 0;
	localparam int OUT_SPR_LO     = 64;
	localparam int OUT_FRAME_LO   = 128;
	localparam int OUT_CHANGE_BIT = 136;
	localparam int OUT_PAUSE_BIT  = 137;

endpackage

/* hw/rtl/sfs_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_divider
// Restoring radix-2 divider giving quotient and remainder, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module sfs_divider #(
	parameter int W = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output sfs_pkg::div_stat_t    stat,
	output logic [W-1:0]          quotient,
	output logic [W-1:0]          remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider finished without running");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CW'(1) |=> busy_q)
		else $error("divider stopped early");
	a_quiet_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !start |=> !busy_q)
		else $error("divider started without a request");

endmodule

/* hw/rtl/sprite_frame_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit
// Sprite animation sequencer: frame and sequence tables in synchronous RAM,
// tick accumulation with frame stepping, one result item per input item.
// ----------------------------------------------------------------------------
// One item is processed at a time. Frame loads, sequence loads, pause toggles,
// unknown kinds and ticks that do not count go from acceptance straight to the
// finish step; a select passes through the sequence read and frame writeback
// steps first, a counting tick that does not step the frame through the
// sequence read and tick steps, and a tick that steps through the sequence
// read, tick, advance and frame writeback steps. The finish step offers the
// result once the output is free. The frame count and the wrap within a
// sequence are normally found by one subtract and compare; when a tick covers
// two or more periods, or the step wraps past the end more than once, a
// serial divider is run in each of those two cases. The sequence RAM and the
// frame RAM each have a registered read port. A new item is accepted while
// the previous result still waits on the output.
module sprite_frame_sequencer_unit #(
	parameter int FRAME_SLOTS    = 256,
	parameter int SEQUENCE_SLOTS = 64,
	parameter int TIME_BITS      = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// delta, visible, slot_index, begin_frame, end_frame, frame_period,
	// texture_box, sprite_box (lowest bit up), zero padding
	input  logic [sfs_pkg::IN_TDATA_W-1:0]      s_tdata,
	// operation
	input  logic [sfs_pkg::OP_W-1:0]            s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// current_texture_box, current_sprite_box, current_frame, frame_changed,
	// is_paused (lowest bit up), zero padding
	output logic [sfs_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int TB    = TIME_BITS;
	localparam int IW    = sfs_pkg::IDX_W;
	localparam int BW    = sfs_pkg::BOX_W;
	localparam int FA    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int SA    = (SEQUENCE_SLOTS > 1) ? $clog2(SEQUENCE_SLOTS) : 1;
	localparam int SEQ_W = 2 * IW + TB;
	localparam logic [16:0] FRAME_LIMIT = 17'(FRAME_SLOTS);
	localparam logic [16:0] SEQ_LIMIT   = 17'(SEQUENCE_SLOTS);

	// Input field slices.
	logic [sfs_pkg::OP_W-1:0] in_op;
	logic [TB-1:0]            in_delta;
	logic                     in_vis;
	logic [IW-1:0]            in_slot;
	logic [IW-1:0]            in_begin;
	logic [IW-1:0]            in_end;
	logic [TB-1:0]            in_period;
	logic [BW-1:0]            in_tex;
	logic [BW-1:0]            in_spr;
	logic                     in_accept;
	logic                     slot_frame_ok;
	logic                     slot_seq_ok;

	assign in_op     = s_tuser;
	assign in_delta  = TB'(s_tdata[sfs_pkg::IN_DELTA_LO +: sfs_pkg::FIELD_T_W]);
	assign in_vis    = s_tdata[sfs_pkg::IN_VIS_BIT];
	assign in_slot   = s_tdata[sfs_pkg::IN_SLOT_LO +: IW];
	assign in_begin  = s_tdata[sfs_pkg::IN_BEGIN_LO +: IW];
	assign in_end    = s_tdata[sfs_pkg::IN_END_LO +: IW];
	assign in_period = TB'(s_tdata[sfs_pkg::IN_PERIOD_LO +: sfs_pkg::FIELD_T_W]);
	assign in_tex    = s_tdata[sfs_pkg::IN_TEX_LO +: BW];
	assign in_spr    = s_tdata[sfs_pkg::IN_SPR_LO +: BW];
	assign in_accept = s_tvalid && s_tready;

	assign slot_frame_ok = {9'd0, in_slot} < FRAME_LIMIT;
	assign slot_seq_ok   = {9'd0, in_slot} < SEQ_LIMIT;

	// Architectural and working registers.
	sfs_pkg::state_t state_q, state_d;
	logic [sfs_pkg::OP_W-1:0] op_q;
	logic [TB-1:0]            delta_q;
	logic [IW-1:0]            slot_q;
	logic [SA-1:0]            active_q;
	logic [IW-1:0]            frame_q;
	logic [TB-1:0]            elapsed_q;
	logic                     paused_q;
	logic [BW-1:0]            tex_q;
	logic [BW-1:0]            spr_q;
	logic                     changed_q;
	logic [TB-1:0]            count_q;
	logic                     out_valid_q;
	logic [sfs_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic [sfs_pkg::OUT_TDATA_W-1:0] out_next;

	// Memories.
	logic [2*BW-1:0]  frame_mem [FRAME_SLOTS];
	logic [SEQ_W-1:0] seq_mem [SEQUENCE_SLOTS];
	logic [2*BW-1:0]  frame_rdata_q;
	logic [SEQ_W-1:0] seq_rdata_q;

	logic          seq_re;
	logic [SA-1:0] seq_raddr;
	logic          frame_re;
	logic [IW-1:0] new_frame;
	logic          new_frame_ok_q;

	// Sequence entry fields.
	logic [IW-1:0] seq_begin;
	logic [IW-1:0] seq_end;
	logic [TB-1:0] seq_period;

	assign seq_begin  = seq_rdata_q[IW-1:0];
	assign seq_end    = seq_rdata_q[2*IW-1:IW];
	assign seq_period = seq_rdata_q[SEQ_W-1:2*IW];

	// Divider.
	logic               div_start;
	logic [TB-1:0]      div_dividend;
	logic [TB-1:0]      div_divisor;
	sfs_pkg::div_stat_t div_stat;
	logic [TB-1:0]      div_quo;
	logic [TB-1:0]      div_rem;

	sfs_divider #(
		.W(TB)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Tick arithmetic.
	logic [TB:0]   sum_full;
	logic [TB-1:0] sum_sat;
	logic [TB-1:0] over_one;
	logic [IW-1:0] to_end;
	logic [IW-1:0] span;
	logic [TB-1:0] rest;
	logic          count_fits;
	logic          rest_fits;

	assign sum_full   = {1'b0, elapsed_q} + {1'b0, delta_q};
	assign sum_sat    = sum_full[TB] ? {TB{1'b1}} : sum_full[TB-1:0];
	assign over_one   = elapsed_q - seq_period;
	assign to_end     = seq_end - frame_q;
	assign span       = seq_end - seq_begin;
	assign count_fits = count_q <= TB'(to_end);
	assign rest       = count_q - TB'(to_end) - TB'(1);
	assign rest_fits  = rest <= TB'(span);

	// Memory ports.
	always_ff @(posedge clk) begin
		if (in_accept && in_op == sfs_pkg::OP_LOAD_FRAME && slot_frame_ok) begin
			frame_mem[FA'(in_slot)] <= {in_spr, in_tex};
		end
		if (frame_re) begin
			frame_rdata_q <= frame_mem[FA'(new_frame)];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && in_op == sfs_pkg::OP_LOAD_SEQ && slot_seq_ok) begin
			seq_mem[SA'(in_slot)] <= {in_period, in_end, in_begin};
		end
		if (seq_re) begin
			seq_rdata_q <= seq_mem[seq_raddr];
		end
	end

	// Next state and control.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		seq_re       = 1'b0;
		seq_raddr    = active_q;
		frame_re     = 1'b0;
		new_frame    = frame_q;
		div_start    = 1'b0;
		div_dividend = elapsed_q;
		div_divisor  = seq_period;
		case (state_q)
			sfs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = sfs_pkg::ST_FINISH;
					case (in_op)
						sfs_pkg::OP_TICK: begin
							if (in_vis && !paused_q) begin
								seq_re  = 1'b1;
								state_d = sfs_pkg::ST_SEQ_RD;
							end
						end
						sfs_pkg::OP_SELECT: begin
							if (slot_seq_ok) begin
								seq_re    = 1'b1;
								seq_raddr = SA'(in_slot);
								state_d   = sfs_pkg::ST_SEQ_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			sfs_pkg::ST_SEQ_RD: begin
				if (op_q == sfs_pkg::OP_SELECT) begin
					new_frame = seq_begin;
					frame_re  = 1'b1;
					state_d   = sfs_pkg::ST_FRAME_WB;
				end else begin
					state_d = sfs_pkg::ST_TICK;
				end
			end
			sfs_pkg::ST_TICK: begin
				if (seq_period == '0 || elapsed_q < seq_period) begin
					state_d = sfs_pkg::ST_FINISH;
				end else if (over_one < seq_period) begin
					state_d = sfs_pkg::ST_ADVANCE;
				end else begin
					div_start = 1'b1;
					state_d   = sfs_pkg::ST_DIV_CNT;
				end
			end
			sfs_pkg::ST_DIV_CNT: begin
				if (div_stat.done) begin
					state_d = sfs_pkg::ST_ADVANCE;
				end
			end
			sfs_pkg::ST_ADVANCE: begin
				div_dividend = rest;
				div_divisor  = TB'({1'b0, span} + 9'd1);
				if (count_fits) begin
					new_frame = frame_q + count_q[IW-1:0];
					frame_re  = 1'b1;
					state_d   = sfs_pkg::ST_FRAME_WB;
				end else if (rest_fits) begin
					new_frame = seq_begin + rest[IW-1:0];
					frame_re  = 1'b1;
					state_d   = sfs_pkg::ST_FRAME_WB;
				end else begin
					div_start = 1'b1;
					state_d   = sfs_pkg::ST_DIV_WRAP;
				end
			end
			sfs_pkg::ST_DIV_WRAP: begin
				if (div_stat.done) begin
					new_frame = seq_begin + div_rem[IW-1:0];
					frame_re  = 1'b1;
					state_d   = sfs_pkg::ST_FRAME_WB;
				end
			end
			sfs_pkg::ST_FRAME_WB: begin
				state_d = sfs_pkg::ST_FINISH;
			end
			sfs_pkg::ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					state_d = sfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Architectural state. These reset values are part of the behaviour.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			frame_q     <= '0;
			elapsed_q   <= '0;
			paused_q    <= 1'b0;
			tex_q       <= '0;
			spr_q       <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				changed_q <= 1'b0;
				if (in_op == sfs_pkg::OP_PAUSE) begin
					paused_q <= !paused_q;
				end
			end
			if (state_q == sfs_pkg::ST_SEQ_RD && op_q == sfs_pkg::OP_SELECT) begin
				active_q <= SA'(slot_q);
			end
			if (state_q == sfs_pkg::ST_SEQ_RD && op_q == sfs_pkg::OP_TICK) begin
				elapsed_q <= sum_sat;
			end
			if (state_q == sfs_pkg::ST_TICK && seq_period != '0 &&
				elapsed_q >= seq_period && over_one < seq_period) begin
				elapsed_q <= over_one;
			end
			if (state_q == sfs_pkg::ST_DIV_CNT && div_stat.done) begin
				elapsed_q <= div_rem;
			end
			if (frame_re) begin
				frame_q <= new_frame;
			end
			if (state_q == sfs_pkg::ST_FRAME_WB) begin
				changed_q <= 1'b1;
				tex_q     <= new_frame_ok_q ? frame_rdata_q[BW-1:0] : '0;
				spr_q     <= new_frame_ok_q ? frame_rdata_q[2*BW-1:BW] : '0;
			end
			if (state_q == sfs_pkg::ST_FINISH && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result item assembly.
	always_comb begin
		out_next = '0;
		out_next[sfs_pkg::OUT_TEX_LO +: BW]   = tex_q;
		out_next[sfs_pkg::OUT_SPR_LO +: BW]   = spr_q;
		out_next[sfs_pkg::OUT_FRAME_LO +: IW] = frame_q;
		out_next[sfs_pkg::OUT_CHANGE_BIT]     = changed_q;
		out_next[sfs_pkg::OUT_PAUSE_BIT]      = paused_q;
	end

	// Item payload and working values.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= in_op;
			delta_q <= in_delta;
			slot_q  <= in_slot;
		end
		if (frame_re) begin
			new_frame_ok_q <= {9'd0, new_frame} < FRAME_LIMIT;
		end
		if (state_q == sfs_pkg::ST_TICK) begin
			count_q <= TB'(1);
		end
		if (state_q == sfs_pkg::ST_DIV_CNT && div_stat.done) begin
			count_q <= div_quo;
		end
		if (state_q == sfs_pkg::ST_FINISH && (!out_valid_q || m_tready)) begin
			out_data_q <= out_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_pause_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(paused_q) |-> $past(in_accept && in_op == sfs_pkg::OP_PAUSE))
		else $error("pause state changed without a pause item");
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sfs_pkg::ST_FINISH))
		else $error("result offered outside the finish step");
	a_idle_divider: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfs_pkg::ST_IDLE |-> !div_stat.busy)
		else $error("divider busy while the sequencer is idle");
	a_step_marks_change: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfs_pkg::ST_FRAME_WB |=> changed_q)
		else $error("frame update not flagged as a change");

endmodule
